// File: hw/rtl/urfrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urfrb_pkg
// Shared types and constants of the UART receive FIFO register block.
// ----------------------------------------------------------------------------
package urfrb_pkg;

   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_RX_BYTE = 2'd2;
   localparam logic [1:0] KIND_ENABLE  = 2'd3;

   localparam logic [3:0] REG_RX_START = 4'd0;
   localparam logic [3:0] REG_RX_SIZE  = 4'd1;
   localparam logic [3:0] REG_RX_CFG   = 4'd2;
   localparam logic [3:0] REG_TX_START = 4'd4;
   localparam logic [3:0] REG_TX_SIZE  = 4'd5;
   localparam logic [3:0] REG_TX_CFG   = 4'd6;
   localparam logic [3:0] REG_SETUP    = 4'd9;
   localparam logic [3:0] REG_ERROR    = 4'd10;
   localparam logic [3:0] REG_IRQ_EN   = 4'd11;
   localparam logic [3:0] REG_VALID    = 4'd12;
   localparam logic [3:0] REG_DATA     = 4'd13;

   localparam int CFG_CONTINUE_BIT = 0;
   localparam int CFG_EN_BIT       = 4;
   localparam int CFG_CLR_BIT      = 6;
   localparam int SETUP_POLL_BIT   = 4;
   localparam int SETUP_CLEAN_BIT  = 5;
   localparam int SETUP_RX_ENA_BIT = 9;
   localparam int IRQ_RX_BIT       = 0;
   localparam int IRQ_ERR_BIT      = 1;
   localparam int ERR_OVERFLOW_BIT = 0;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  word_index;
      logic [31:0] write_data;
      logic [7:0]  rx_byte;
      logic        enable_level;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        rx_irq;
      logic        error_irq;
      logic        data_valid;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   typedef struct packed {
      logic [7:0] head;
      logic       empty;
      logic       full;
   } fifo_sts_type;

endpackage

// File: hw/rtl/urfrb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urfrb_fifo
// Shift-register receive FIFO: head always at entry 0, push at the fill count.
// ----------------------------------------------------------------------------
module urfrb_fifo #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  urfrb_pkg::fifo_ctl_type ctl,
   input  logic [7:0]            push_byte,
   output urfrb_pkg::fifo_sts_type sts,
   output logic                  next_empty
);
   import urfrb_pkg::*;

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   logic [7:0]       entry_ff [FIFO_DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.flush) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[count_ff[IDX_W-1:0]] <= push_byte;
      end else if (ctl.pop) begin
         for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
            entry_ff[i] <= entry_ff[i+1];
         end
      end
   end

   assign sts.head   = entry_ff[0];
   assign sts.empty  = (count_ff == '0);
   assign sts.full   = (count_ff == CNT_W'(FIFO_DEPTH));
   assign next_empty = (count_in == '0);

endmodule

// File: hw/rtl/urfrb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urfrb_regs
// Register file, bus decode, receive gating and interrupt derivation.
// ----------------------------------------------------------------------------
module urfrb_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  urfrb_pkg::req_item_type req,
   input  urfrb_pkg::fifo_sts_type fifo_sts,
   input  logic                    fifo_next_empty,
   output urfrb_pkg::fifo_ctl_type fifo_ctl,
   output urfrb_pkg::rsp_item_type rsp
);
   import urfrb_pkg::*;

   typedef struct packed {
      logic [31:0] cfg;
      logic [31:0] addr;
      logic [31:0] len;
   } chan_type;

   function automatic chan_type chan_write(input chan_type cur, input logic [31:0] start,
                                           input logic [31:0] size, input logic [31:0] value);
      chan_type r;
      r = cur;
      if (!cur.cfg[CFG_EN_BIT] && value[CFG_EN_BIT]) begin
         r.addr = start;
         r.len  = size;
      end
      if (value[CFG_CLR_BIT]) begin
         r.addr = '0;
         r.len  = '0;
         r.cfg  = {31'b0, value[CFG_CONTINUE_BIT]};
      end else begin
         r.cfg = value;
         r.cfg[CFG_CLR_BIT] = 1'b0;
      end
      return r;
   endfunction

   logic        enabled_ff, enabled_in;
   logic [31:0] rx_start_ff, rx_start_in;
   logic [31:0] rx_size_ff, rx_size_in;
   chan_type    rx_chan_ff, rx_chan_in;
   logic [31:0] tx_start_ff, tx_start_in;
   logic [31:0] tx_size_ff, tx_size_in;
   chan_type    tx_chan_ff, tx_chan_in;
   logic [31:0] setup_ff, setup_in;
   logic [1:0]  error_ff, error_in;
   logic [31:0] irq_en_ff, irq_en_in;
   logic [7:0]  last_ff, last_in;
   logic        rx_mode;
   logic [31:0] rdata;
   logic [31:0] wdata;

   assign rx_mode = irq_en_ff[IRQ_RX_BIT] | setup_ff[SETUP_POLL_BIT];
   assign wdata   = req.write_data;

   always_comb begin
      enabled_in = enabled_ff;
      rx_start_in = rx_start_ff;
      rx_size_in  = rx_size_ff;
      rx_chan_in  = rx_chan_ff;
      tx_start_in = tx_start_ff;
      tx_size_in  = tx_size_ff;
      tx_chan_in  = tx_chan_ff;
      setup_in    = setup_ff;
      error_in    = error_ff;
      irq_en_in   = irq_en_ff;
      last_in     = last_ff;
      rdata       = '0;
      fifo_ctl    = '0;
      if (step) begin
         unique case (req.req_type)
            KIND_READ: begin
               if (enabled_ff) begin
                  unique case (req.word_index)
                     REG_RX_START: rdata = rx_chan_ff.addr;
                     REG_RX_SIZE:  rdata = rx_chan_ff.len;
                     REG_RX_CFG:   rdata = rx_chan_ff.cfg;
                     REG_TX_START: rdata = tx_chan_ff.addr;
                     REG_TX_SIZE:  rdata = tx_chan_ff.len;
                     REG_TX_CFG:   rdata = tx_chan_ff.cfg;
                     REG_SETUP:    rdata = setup_ff;
                     REG_ERROR: begin
                        rdata    = {30'b0, error_ff};
                        error_in = '0;
                     end
                     REG_IRQ_EN:   rdata = irq_en_ff;
                     REG_VALID:    rdata = {31'b0, rx_mode & ~fifo_sts.empty};
                     REG_DATA: begin
                        if (rx_mode && !fifo_sts.empty) begin
                           last_in      = fifo_sts.head;
                           fifo_ctl.pop = 1'b1;
                        end
                        rdata = {24'b0, last_in};
                     end
                     default:      rdata = '0;
                  endcase
               end
            end
            KIND_WRITE: begin
               if (enabled_ff) begin
                  unique case (req.word_index)
                     REG_RX_START: rx_start_in = wdata;
                     REG_RX_SIZE:  rx_size_in  = wdata;
                     REG_RX_CFG:
                        rx_chan_in = chan_write(rx_chan_ff, rx_start_ff, rx_size_ff, wdata);
                     REG_TX_START: tx_start_in = wdata;
                     REG_TX_SIZE:  tx_size_in  = wdata;
                     REG_TX_CFG:
                        tx_chan_in = chan_write(tx_chan_ff, tx_start_ff, tx_size_ff, wdata);
                     REG_SETUP: begin
                        setup_in = wdata;
                        setup_in[SETUP_CLEAN_BIT] = 1'b0;
                        fifo_ctl.flush = wdata[SETUP_CLEAN_BIT];
                     end
                     REG_IRQ_EN:   irq_en_in = wdata;
                     default: ;
                  endcase
               end
            end
            KIND_RX_BYTE: begin
               if (enabled_ff && (setup_ff[SETUP_RX_ENA_BIT] || rx_mode)) begin
                  if (fifo_sts.full) begin
                     error_in[ERR_OVERFLOW_BIT] = 1'b1;
                  end else begin
                     fifo_ctl.push = 1'b1;
                  end
               end
            end
            KIND_ENABLE: enabled_in = req.enable_level;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         rx_start_ff <= '0;
         rx_size_ff  <= '0;
         rx_chan_ff  <= '0;
         tx_start_ff <= '0;
         tx_size_ff  <= '0;
         tx_chan_ff  <= '0;
         setup_ff    <= '0;
         error_ff    <= '0;
         irq_en_ff   <= '0;
         last_ff     <= '0;
      end else begin
         enabled_ff  <= enabled_in;
         rx_start_ff <= rx_start_in;
         rx_size_ff  <= rx_size_in;
         rx_chan_ff  <= rx_chan_in;
         tx_start_ff <= tx_start_in;
         tx_size_ff  <= tx_size_in;
         tx_chan_ff  <= tx_chan_in;
         setup_ff    <= setup_in;
         error_ff    <= error_in;
         irq_en_ff   <= irq_en_in;
         last_ff     <= last_in;
      end
   end

   assign rsp.read_data  = rdata;
   assign rsp.rx_irq     = ~fifo_next_empty & irq_en_in[IRQ_RX_BIT]
                           & ~setup_in[SETUP_POLL_BIT];
   assign rsp.error_irq  = (|error_in) & irq_en_in[IRQ_ERR_BIT];
   assign rsp.data_valid = ~fifo_next_empty
                           & (irq_en_in[IRQ_RX_BIT] | setup_in[SETUP_POLL_BIT]);

endmodule

// File: hw/rtl/uart_rx_fifo_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_register_block
// UART register block with a receive FIFO, one request per transfer.
// ----------------------------------------------------------------------------
// Each request transfer (bus read, bus write, received byte or enable level)
// updates the register state in the cycle it is taken and loads one response
// into the output register, so while responses are taken the block sustains
// one transfer per cycle; the response appears the cycle after its request.
// A new request is taken while a response is held, if that response is taken
// in the same cycle. The receive FIFO is FIFO_DEPTH entries of shift register.
module uart_rx_fifo_register_block #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  urfrb_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output urfrb_pkg::rsp_item_type rsp_data
);
   import urfrb_pkg::*;

   logic         step;
   fifo_ctl_type fifo_ctl;
   fifo_sts_type fifo_sts;
   logic         fifo_next_empty;
   rsp_item_type rsp_in;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   urfrb_regs u_regs (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .req             (req_data),
      .fifo_sts        (fifo_sts),
      .fifo_next_empty (fifo_next_empty),
      .fifo_ctl        (fifo_ctl),
      .rsp             (rsp_in)
   );

   urfrb_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fifo_ctl),
      .push_byte  (req_data.rx_byte),
      .sts        (fifo_sts),
      .next_empty (fifo_next_empty)
   );

   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
